>>> sv/cflr_pkg.sv
// ----------------------------------------------------------------------------
// cflr_pkg
// types, character codes and classifier functions for the float literal lexer
// ----------------------------------------------------------------------------
package cflr_pkg;

   localparam int LENGTH_BITS  = 12;
   localparam int LEN_OUT_BITS = 12;
   localparam int CHAR_BITS    = 21;

   typedef logic [CHAR_BITS-1:0]   char_type;
   typedef logic [LENGTH_BITS-1:0] count_type;

   localparam char_type CH_0     = 21'h30;
   localparam char_type CH_9     = 21'h39;
   localparam char_type CH_LA    = 21'h61;
   localparam char_type CH_LF    = 21'h66;
   localparam char_type CH_UA    = 21'h41;
   localparam char_type CH_UF    = 21'h46;
   localparam char_type CH_LX    = 21'h78;
   localparam char_type CH_UX    = 21'h58;
   localparam char_type CH_DOT   = 21'h2e;
   localparam char_type CH_LE    = 21'h65;
   localparam char_type CH_UE    = 21'h45;
   localparam char_type CH_LP    = 21'h70;
   localparam char_type CH_UP    = 21'h50;
   localparam char_type CH_PLUS  = 21'h2b;
   localparam char_type CH_MINUS = 21'h2d;
   localparam char_type CH_LL    = 21'h6c;
   localparam char_type CH_UL    = 21'h4c;

   typedef enum logic [1:0] {
      SFX_NONE  = 2'd0,
      SFX_FLOAT = 2'd1,
      SFX_LONG  = 2'd2
   } suffix_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ZERO, PH_INT, PH_LDOT, PH_FRAC, PH_QE, PH_QS,
      PH_SE, PH_SS, PH_EXPD, PH_HX, PH_HI, PH_HDOT0, PH_HF
   } phase_type;

   typedef enum logic [1:0] {
      ACT_TAKE, ACT_MATCH, ACT_FAIL, ACT_SUFFIX
   } act_type;

   typedef struct packed {
      logic     first;
      logic     at_end;
      char_type character;
   } req_type;

   typedef struct packed {
      logic                    consumed;
      logic                    done_res;
      logic                    matched;
      logic [LEN_OUT_BITS-1:0] token_length;
      logic [1:0]              suffix_kind;
      logic                    overflow;
   } rsp_type;

   function automatic logic is_dec(input char_type c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_hex(input char_type c);
      return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
   endfunction

   function automatic logic is_sign(input char_type c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic suffix_type suffix_of(input char_type c);
      suffix_type s;
      s = SFX_NONE;
      if ((c == CH_LF) || (c == CH_UF)) begin
         s = SFX_FLOAT;
      end else if ((c == CH_LL) || (c == CH_UL)) begin
         s = SFX_LONG;
      end
      return s;
   endfunction

endpackage

>>> sv/c_float_literal_recognizer.sv
// ----------------------------------------------------------------------------
// c_float_literal_recognizer
// lexer for c floating constants, one code point per request
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel carries one peeked code point,
// a first flag that opens a new match attempt and an at_end flag for an
// exhausted input. Each request gives exactly one response on rsp_: whether
// the character joined the token, whether the attempt finished, the verdict,
// the running token length (saturating, with overflow), and the suffix kind.
// A request is held in the input register, and the state step writes its
// response into the response register, where rsp_valid rises.
// Throughput is one request per cycle while rsp_ready stays high; the
// phase/length update is a single combinational step, so consecutive
// characters of a token stream back to back.
// Reset (synchronous, active high) empties both registers and returns the
// lexer to idle with a zero length.
// When the receiver stalls, the response register holds, the input register
// fills, and req_ready drops until rsp_ready frees the response register.
// ----------------------------------------------------------------------------
module c_float_literal_recognizer
   import cflr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type   req_ff;
   logic      req_valid_ff, req_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   phase_type phase_ff, phase_in;
   count_type count_ff, count_in;
   logic      sat_ff, sat_in;

   logic       advance;
   logic       restart;
   phase_type  cur_phase;
   phase_type  nxt;
   act_type    act;
   char_type   c;
   suffix_type sk;
   count_type  base_count;
   logic       base_sat;
   logic       take;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // next phase and action
   always_comb begin
      restart   = req_ff.first || (phase_ff == PH_IDLE);
      cur_phase = restart ? PH_IDLE : phase_ff;
      c         = req_ff.at_end ? '0 : req_ff.character;
      sk        = suffix_of(c);
      act       = ACT_FAIL;
      nxt       = PH_IDLE;
      case (cur_phase)
         PH_IDLE: begin
            if (c == CH_0) begin
               act = ACT_TAKE; nxt = PH_ZERO;
            end else if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_INT;
            end else if (c == CH_DOT) begin
               act = ACT_TAKE; nxt = PH_LDOT;
            end
         end
         PH_ZERO: begin
            if ((c == CH_LX) || (c == CH_UX)) begin
               act = ACT_TAKE; nxt = PH_HX;
            end else if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_INT;
            end else if (c == CH_DOT) begin
               act = ACT_TAKE; nxt = PH_FRAC;
            end else if ((c == CH_LE) || (c == CH_UE)) begin
               act = ACT_TAKE; nxt = PH_SE;
            end
         end
         PH_INT: begin
            if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_INT;
            end else if (c == CH_DOT) begin
               act = ACT_TAKE; nxt = PH_FRAC;
            end else if ((c == CH_LE) || (c == CH_UE)) begin
               act = ACT_TAKE; nxt = PH_SE;
            end
         end
         PH_LDOT: begin
            if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_FRAC;
            end
         end
         PH_FRAC: begin
            if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_FRAC;
            end else if ((c == CH_LE) || (c == CH_UE)) begin
               act = ACT_TAKE; nxt = PH_QE;
            end else if (sk != SFX_NONE) begin
               act = ACT_SUFFIX;
            end else begin
               act = ACT_MATCH;
            end
         end
         PH_QE: begin
            if (is_sign(c)) begin
               act = ACT_TAKE; nxt = PH_QS;
            end else if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_EXPD;
            end else if (sk != SFX_NONE) begin
               act = ACT_SUFFIX;
            end else begin
               act = ACT_MATCH;
            end
         end
         PH_QS: begin
            if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_EXPD;
            end else if (sk != SFX_NONE) begin
               act = ACT_SUFFIX;
            end else begin
               act = ACT_MATCH;
            end
         end
         PH_SE: begin
            if (is_sign(c)) begin
               act = ACT_TAKE; nxt = PH_SS;
            end else if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_EXPD;
            end
         end
         PH_SS: begin
            if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_EXPD;
            end
         end
         PH_EXPD: begin
            if (is_dec(c)) begin
               act = ACT_TAKE; nxt = PH_EXPD;
            end else if (sk != SFX_NONE) begin
               act = ACT_SUFFIX;
            end else begin
               act = ACT_MATCH;
            end
         end
         PH_HX: begin
            if (is_hex(c)) begin
               act = ACT_TAKE; nxt = PH_HI;
            end else if (c == CH_DOT) begin
               act = ACT_TAKE; nxt = PH_HDOT0;
            end
         end
         PH_HI: begin
            if (is_hex(c)) begin
               act = ACT_TAKE; nxt = PH_HI;
            end else if (c == CH_DOT) begin
               act = ACT_TAKE; nxt = PH_HF;
            end else if ((c == CH_LP) || (c == CH_UP)) begin
               act = ACT_TAKE; nxt = PH_SE;
            end
         end
         PH_HDOT0: begin
            if (is_hex(c)) begin
               act = ACT_TAKE; nxt = PH_HF;
            end
         end
         PH_HF: begin
            if (is_hex(c)) begin
               act = ACT_TAKE; nxt = PH_HF;
            end else if ((c == CH_LP) || (c == CH_UP)) begin
               act = ACT_TAKE; nxt = PH_SE;
            end
         end
         default: begin
            act = ACT_FAIL;
            nxt = PH_IDLE;
         end
      endcase
      phase_in = (act == ACT_TAKE) ? nxt : PH_IDLE;
   end

   // length counter and response
   always_comb begin
      base_count = restart ? '0 : count_ff;
      base_sat   = restart ? 1'b0 : sat_ff;
      take       = (act == ACT_TAKE) || (act == ACT_SUFFIX);
      count_in   = base_count;
      sat_in     = base_sat;
      if (take) begin
         if (base_count == {LENGTH_BITS{1'b1}}) begin
            sat_in = 1'b1;
         end else begin
            count_in = base_count + LENGTH_BITS'(1);
         end
      end
      rsp_in.consumed     = take;
      rsp_in.done_res     = (act != ACT_TAKE);
      rsp_in.matched      = (act == ACT_MATCH) || (act == ACT_SUFFIX);
      rsp_in.token_length = LEN_OUT_BITS'(count_in);
      rsp_in.suffix_kind  = (act == ACT_SUFFIX) ? sk : SFX_NONE;
      rsp_in.overflow     = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            sat_ff   <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/cflr_checker.sv
// ----------------------------------------------------------------------------
// cflr_checker
// port-level checks on the float literal lexer, bound to the top level
// ----------------------------------------------------------------------------
module cflr_checker
   import cflr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an unconsumed character always ends the attempt
   a_unconsumed_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.consumed |-> rsp_data.done_res)
      else $error("unconsumed character without done");

   // no verdict or suffix while the attempt runs
   a_open_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> !rsp_data.matched && (rsp_data.suffix_kind == SFX_NONE))
      else $error("verdict on open attempt");

   // a suffix is consumed and closes a match
   a_suffix_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.suffix_kind != SFX_NONE) |->
         rsp_data.consumed && rsp_data.done_res && rsp_data.matched &&
         (rsp_data.suffix_kind != 2'd3))
      else $error("bad suffix response");

endmodule

bind c_float_literal_recognizer cflr_checker u_cflr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
